/* rtl/alir_pkg.sv */
// Package for the array list insert/remove core.
// Field widths, opcode and status codes, controller/datapath command and status types.
// No dependencies.
package alir_pkg;

    localparam int DEPTH_DEF = 128;

    localparam int OPCODE_W  = 3;
    localparam int VALUE_W   = 32;
    localparam int POS_W     = 8;
    localparam int STATUS_W  = 2;
    localparam int LEN_W     = 8;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;

    localparam logic [OPCODE_W-1:0] OP_APPEND     = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_PREPEND    = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_INSERT_AT  = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_REMOVE_AT  = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_REMOVE_VAL = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_READ       = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic                capture;
        logic                ins;
        logic                rem;
        logic                scan_step;
        logic                drop;
        logic                commit;
        logic                out_load;
        logic [STATUS_W-1:0] status;
    } alir_cmd_t;

    typedef struct packed {
        logic full;
        logic ins_ok;
        logic idx_ok;
        logic scan_end;
    } alir_stat_t;

endpackage

/* rtl/alir_ctrl.sv */
// Controller for the array list core: handshakes, opcode decode and sequencing.
// Drives alir_cmd_t towards the datapath, reads alir_stat_t back. Uses alir_pkg.
module alir_ctrl
    import alir_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [OPCODE_W-1:0] s_opcode,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  alir_stat_t          stat,
    output alir_cmd_t           cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [OPCODE_W-1:0] op_reg;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                m_tvalid_reg;
    logic                slot_free;
    logic                accept;

    assign slot_free = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE) || ((state_reg == S_DONE) && slot_free);
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;

    always_comb begin
        state_next   = state_reg;
        status_next  = status_reg;
        cmd          = '0;
        cmd.capture  = accept;
        cmd.drop     = (op_reg == OP_REMOVE_VAL);
        cmd.status   = status_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_DONE;
                unique case (op_reg)
                    OP_APPEND, OP_PREPEND, OP_INSERT_AT: begin
                        if (stat.full) begin
                            status_next = ST_FULL;
                        end else if (!stat.ins_ok) begin
                            status_next = ST_RANGE;
                        end else begin
                            status_next = ST_OK;
                            cmd.ins     = 1'b1;
                        end
                    end
                    OP_REMOVE_AT: begin
                        if (!stat.idx_ok) begin
                            status_next = ST_RANGE;
                        end else begin
                            status_next = ST_OK;
                            cmd.rem     = 1'b1;
                        end
                    end
                    OP_REMOVE_VAL: begin
                        status_next = ST_OK;
                        state_next  = S_SCAN;
                    end
                    OP_READ: begin
                        if (!stat.idx_ok) begin
                            status_next = ST_RANGE;
                        end else begin
                            status_next = ST_OK;
                            state_next  = S_SCAN;
                        end
                    end
                    default: begin
                        status_next = ST_RANGE;
                    end
                endcase
            end
            S_SCAN: begin
                if (stat.scan_end) begin
                    cmd.commit = 1'b1;
                    state_next = S_DONE;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_DONE: begin
                if (slot_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = accept ? S_EXEC : S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        if (accept) begin
            op_reg <= s_opcode;
        end
    end

endmodule

/* rtl/alir_datapath.sv */
// Datapath for the array list core: cell chain, length, scan counters and result register.
// Acts on alir_cmd_t from alir_ctrl and reports alir_stat_t. Uses alir_pkg.
module alir_datapath
    import alir_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [OPCODE_W-1:0]  s_opcode,
    input  logic [VALUE_W-1:0]   s_item_value,
    input  logic [POS_W-1:0]     s_item_position,
    input  alir_cmd_t            cmd,
    output alir_stat_t           stat,
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;
    localparam int PAD_W = M_TDATA_W - VALUE_W - LEN_W - STATUS_W;

    logic [VALUE_W-1:0]   cell_reg [DEPTH];
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        len_reg;
    logic [CW-1:0]        step_reg;
    logic [XW-1:0]        pos_reg;
    logic [VALUE_W-1:0]   val_reg;
    logic [VALUE_W-1:0]   rd_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [XW-1:0]        pos_in;
    logic [XW-1:0]        count_x;
    logic [CW-1:0]        len_m1;
    logic                 head_match;
    logic                 keep;

    assign count_x    = XW'(count_reg);
    assign len_m1     = len_reg - 1'b1;
    assign head_match = (cell_reg[0] == val_reg);
    assign keep       = !(cmd.drop && head_match);

    always_comb begin
        unique case (s_opcode)
            OP_APPEND:  pos_in = count_x;
            OP_PREPEND: pos_in = '0;
            default:    pos_in = XW'(s_item_position);
        endcase
    end

    assign stat.full     = (count_reg == CW'(DEPTH));
    assign stat.ins_ok   = (pos_reg <= count_x);
    assign stat.idx_ok   = (pos_reg < count_x);
    assign stat.scan_end = (step_reg == count_reg);

    for (genvar j = 0; j < DEPTH; j++) begin : g_cell
        logic [VALUE_W-1:0] below;
        logic [VALUE_W-1:0] above;
        logic [VALUE_W-1:0] cell_next;

        if (j > 0) begin : g_below
            assign below = cell_reg[j-1];
        end else begin : g_bottom
            assign below = cell_reg[j];
        end

        if (j < DEPTH - 1) begin : g_above
            assign above = cell_reg[j+1];
        end else begin : g_top
            assign above = cell_reg[j];
        end

        always_comb begin
            cell_next = cell_reg[j];
            if (cmd.ins) begin
                if (XW'(j) == pos_reg) begin
                    cell_next = val_reg;
                end else if (XW'(j) > pos_reg) begin
                    cell_next = below;
                end
            end else if (cmd.rem) begin
                if (XW'(j) >= pos_reg) begin
                    cell_next = above;
                end
            end else if (cmd.scan_step) begin
                if (keep && (CW'(j) == len_m1)) begin
                    cell_next = cell_reg[0];
                end else begin
                    cell_next = above;
                end
            end
        end

        always_ff @(posedge aclk) begin
            cell_reg[j] <= cell_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.ins) begin
            count_reg <= count_reg + 1'b1;
        end else if (cmd.rem) begin
            count_reg <= count_reg - 1'b1;
        end else if (cmd.commit) begin
            count_reg <= len_reg;
        end
    end

    // scan rotates the live part of the chain once round; dropped heads are not written back
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            pos_reg  <= pos_in;
            val_reg  <= s_item_value;
            len_reg  <= count_reg;
            step_reg <= '0;
            rd_reg   <= '0;
        end else if (cmd.scan_step) begin
            step_reg <= step_reg + 1'b1;
            if (!keep) begin
                len_reg <= len_m1;
            end
            if (!cmd.drop && (XW'(step_reg) == pos_reg)) begin
                rd_reg <= cell_reg[0];
            end
        end
        if (cmd.out_load) begin
            m_tdata_reg <= {PAD_W'(0), rd_reg, LEN_W'(count_reg), cmd.status};
        end
    end

    assign m_tdata = m_tdata_reg;

endmodule

/* rtl/array_list_insert_remove_core.sv */
// Top level of the array list insert/remove core.
// Instantiates alir_ctrl and alir_datapath; uses alir_pkg.
//
// Ordered list of up to DEPTH signed 32-bit entries held in a chain of cells.
// Append, prepend and insert at move the entries from the position up, and remove
// at down, by one place in one update of the cells. Remove by value and an in-range read
// rotate the live entries once through the head cell, one entry a cycle; an
// out-of-range read, a refused insert and an unused opcode do not scan.
// One beat is worked on at a time; a finished result waits in the output
// register while the next beat is taken. No clearing pass after reset.
module array_list_insert_remove_core
    import alir_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // opcode[2:0], item_value[34:3], item_position[42:35]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // status[1:0], list_length[9:2], read_value[41:10]
);

    alir_cmd_t  cmd;
    alir_stat_t stat;

    logic [OPCODE_W-1:0] s_opcode;
    logic [VALUE_W-1:0]  s_item_value;
    logic [POS_W-1:0]    s_item_position;

    assign s_opcode        = s_tdata[OPCODE_W-1:0];
    assign s_item_value    = s_tdata[OPCODE_W +: VALUE_W];
    assign s_item_position = s_tdata[OPCODE_W + VALUE_W +: POS_W];

    alir_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_opcode (s_opcode),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    alir_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_opcode        (s_opcode),
        .s_item_value    (s_item_value),
        .s_item_position (s_item_position),
        .cmd             (cmd),
        .stat            (stat),
        .m_tdata         (m_tdata)
    );

endmodule

/* rtl/alir_checker.sv */
// Port-level checks for array_list_insert_remove_core, attached by bind.
// Uses alir_pkg for widths and status codes.
module alir_checker
    import alir_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second beat taken while one is being worked on");

    a_refused_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[STATUS_W-1:0] != ST_OK)
        |-> (m_tdata[STATUS_W + LEN_W +: VALUE_W] == '0)
            && ((m_tdata[STATUS_W-1:0] == ST_FULL) || (m_tdata[STATUS_W-1:0] == ST_RANGE)))
        else $error("refused beat carries read data or bad status");

endmodule

bind array_list_insert_remove_core alir_checker u_alir_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* verif/array_list_insert_remove_core_tb.sv */
// Testbench for array_list_insert_remove_core: drives opcode beats and checks every result
// beat against a list predictor kept in a small scoreboard class.
// Depends on alir_pkg and the core RTL only.
module array_list_insert_remove_core_tb
    import alir_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_DEPTH = DEPTH_DEF;
    localparam logic [OPCODE_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [LEN_W-1:0]    length;
        logic [VALUE_W-1:0]  value;
    } list_result_t;

    class list_tracker;
        logic [VALUE_W-1:0] cells [LIST_DEPTH];
        int                 fill;
        list_result_t       pending_results [$];
        int                 errors;

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        function int size();
            return fill;
        endfunction

        function logic [VALUE_W-1:0] entry(int idx);
            return cells[idx];
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void note_request(logic [OPCODE_W-1:0] op, logic [VALUE_W-1:0] val,
                                   logic [POS_W-1:0] pos);
            list_result_t r;
            int           at;
            int           w;
            r        = '0;
            r.status = ST_OK;
            case (op)
                OP_APPEND, OP_PREPEND, OP_INSERT_AT: begin
                    at = (op == OP_APPEND) ? fill : (op == OP_PREPEND) ? 0 : int'(pos);
                    if (fill >= LIST_DEPTH) begin
                        r.status = ST_FULL;
                    end else if (at > fill) begin
                        r.status = ST_RANGE;
                    end else begin
                        for (int i = fill; i > at; i--) cells[i] = cells[i-1];
                        cells[at] = val;
                        fill++;
                    end
                end
                OP_REMOVE_AT: begin
                    if (int'(pos) >= fill) begin
                        r.status = ST_RANGE;
                    end else begin
                        for (int i = int'(pos); i + 1 < fill; i++) cells[i] = cells[i+1];
                        fill--;
                    end
                end
                OP_REMOVE_VAL: begin
                    w = 0;
                    for (int i = 0; i < fill; i++) begin
                        if (cells[i] != val) begin
                            cells[w] = cells[i];
                            w++;
                        end
                    end
                    fill = w;
                end
                OP_READ: begin
                    if (int'(pos) >= fill) r.status = ST_RANGE;
                    else r.value = cells[pos];
                end
                default: r.status = ST_RANGE;
            endcase
            r.length = fill[LEN_W-1:0];
            pending_results.push_back(r);
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] beat);
            list_result_t want;
            list_result_t got;
            got.status = beat[1:0];
            got.length = beat[9:2];
            got.value  = beat[41:10];
            if (pending_results.size() == 0) begin
                $display("%0t: result beat with none expected, tdata %h", $time, beat);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
                errors++;
            end
            if (got.length !== want.length) begin
                $display("%0t: length expected %0d actual %0d", $time, want.length, got.length);
                errors++;
            end
            if (got.value !== want.value) begin
                $display("%0t: read value expected %0d actual %0d", $time,
                         $signed(want.value), $signed(got.value));
                errors++;
            end
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    list_tracker lists = new();

    array_list_insert_remove_core #(
        .DEPTH(LIST_DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic int idle_len(bit burst);
        int r;
        r = $urandom_range(0, 99);
        if (burst) return 0;
        if (r < 70) return $urandom_range(0, 1);
        if (r < 95) return $urandom_range(2, 5);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [OPCODE_W-1:0] pick_opcode(int phase);
        int r;
        int c [6];
        r = $urandom_range(0, 99);
        case (phase)
            0:       c = '{30, 52, 88, 92, 93, 98};
            1:       c = '{15, 25, 45, 70, 80, 97};
            default: c = '{5, 10, 20, 65, 80, 97};
        endcase
        if (r < c[0]) return OP_APPEND;
        if (r < c[1]) return OP_PREPEND;
        if (r < c[2]) return OP_INSERT_AT;
        if (r < c[3]) return OP_REMOVE_AT;
        if (r < c[4]) return OP_REMOVE_VAL;
        if (r < c[5]) return OP_READ;
        return $urandom_range(0, 1) ? OP_SPARE_7 : OP_SPARE_6;
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value(logic [OPCODE_W-1:0] op);
        int r;
        int n;
        r = $urandom_range(0, 9);
        n = lists.size();
        if (op == OP_REMOVE_VAL && n > 0 && $urandom_range(0, 9) < 7)
            return lists.entry($urandom_range(0, n - 1));
        if (r < 5) return VALUE_W'($signed($urandom_range(0, 6)) - 3);
        if (r == 5) begin
            case ($urandom_range(0, 3))
                0:       return 32'h7FFF_FFFF;
                1:       return 32'h8000_0000;
                2:       return 32'h0;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        return $urandom();
    endfunction

    function automatic logic [POS_W-1:0] pick_position(logic [OPCODE_W-1:0] op);
        int r;
        int hi;
        r = $urandom_range(0, 99);
        if (op == OP_INSERT_AT) hi = lists.size();
        else if (op == OP_REMOVE_AT || op == OP_READ) hi = lists.size() - 1;
        else return POS_W'($urandom_range(0, 255));
        if (r < 85 && hi >= 0) return POS_W'($urandom_range(0, hi));
        if (r < 95) return POS_W'(hi + 1 + int'($urandom_range(0, 3)));
        return POS_W'($urandom_range(0, 255));
    endfunction

    task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [VALUE_W-1:0] val,
                             input logic [POS_W-1:0] pos, input int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, pos, val, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        lists.note_request(op, val, pos);
    endtask

    // result side: consumer with random stalls and one long hold-off
    initial begin
        int hold;
        int seen;
        bit burst;
        bit pressed;
        hold     = 0;
        seen     = 0;
        burst    = 1'b0;
        pressed  = 1'b0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                lists.check_result(m_tdata);
                seen++;
            end
            if (!pressed && seen == 60) begin
                pressed = 1'b1;
                hold    = 400;
            end
            if ($urandom_range(0, 49) == 0) burst = !burst;
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (!burst && $urandom_range(0, 3) == 0) hold = idle_len(1'b0);
            end
        end
    end

    initial begin
        logic [OPCODE_W-1:0] op;
        int                  phase;
        bit                  burst;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        burst    = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty list: refused reads and removes, harmless remove by value
        send_item(OP_READ,       32'd0,        8'd0,   0);
        send_item(OP_REMOVE_AT,  32'd0,        8'd0,   1);
        send_item(OP_REMOVE_VAL, 32'd0,        8'd0,   0);
        send_item(OP_APPEND,     32'h7FFF_FFFF, 8'd0,  0);
        send_item(OP_PREPEND,    32'h8000_0000, 8'd255, 2);
        send_item(OP_INSERT_AT,  32'd5,        8'd1,   0);
        send_item(OP_INSERT_AT,  32'd5,        8'd1,   0);
        send_item(OP_INSERT_AT,  32'd9,        8'd5,   0);
        send_item(OP_INSERT_AT,  32'hFFFF_FFFF, 8'd4,  0);
        send_item(OP_READ,       32'd0,        8'd0,   0);
        send_item(OP_READ,       32'd0,        8'd4,   3);
        send_item(OP_READ,       32'd0,        8'd5,   0);
        send_item(OP_READ,       32'hFFFF_FFFF, 8'd255, 0);
        send_item(OP_REMOVE_VAL, 32'd5,        8'd0,   0);
        send_item(OP_REMOVE_AT,  32'd0,        8'd255, 0);
        send_item(OP_SPARE_6,    32'd1,        8'd0,   0);
        send_item(OP_SPARE_7,    32'hFFFF_FFFF, 8'd255, 0);
        send_item(OP_REMOVE_AT,  32'd0,        8'd2,   0);
        send_item(OP_REMOVE_AT,  32'd0,        8'd0,   0);
        send_item(OP_APPEND,     32'd0,        8'd0,   0);
        send_item(OP_REMOVE_VAL, 32'd0,        8'd0,   0);

        // fill-heavy, then balanced, then drain-heavy
        for (int k = 0; k < 600; k++) begin
            phase = (k < 250) ? 0 : (k < 450) ? 1 : 2;
            if ($urandom_range(0, 39) == 0) burst = !burst;
            op = pick_opcode(phase);
            send_item(op, pick_value(op), pick_position(op), idle_len(burst));
        end
        s_tvalid <= 1'b0;

        while (lists.pending() > 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (lists.errors == 0 && lists.pending() == 0) begin
            $display("array_list_insert_remove_core test passed");
        end else begin
            $display("array_list_insert_remove_core test failed");
        end
        $finish;
    end

    initial begin
        #15_000_000;
        $display("%0t: timed out with %0d results outstanding", $time, lists.pending());
        $display("array_list_insert_remove_core test failed");
        $finish;
    end

endmodule
